[sv/iis_pkg.sv]
// ----------------------------------------------------------------------------
// iis_pkg
// Shared types, field widths, constants and datapath command codes for the
// imputation info score block.
// ----------------------------------------------------------------------------
package iis_pkg;

  // probability format
  localparam int PROB_W         = 16;
  localparam int PROB_FRAC_BITS = 15;

  // default site size limit
  localparam int MAX_SAMPLES_DEF = 65536;

  // result field widths
  localparam int INFO_W = 10;
  localparam int FREQ_W = 7;
  localparam int SEEN_W = 17;

  // per-sample term widths
  localparam int A0_W   = PROB_W + 2;   // p1 + 2*p2
  localparam int A1_W   = PROB_W + 3;   // p1 + 4*p2
  localparam int SQ_W   = 2 * A0_W;     // a0^2
  localparam int TERM_W = SQ_W + 1;     // signed variance term

  // iteration counts of the shared divide loop
  localparam int FQ_STEPS   = 9;        // frequency quotient stays below 512
  localparam int IDIV_STEPS = 12;       // top quotient bit flags a zero score
  localparam int QUO_W      = IDIV_STEPS;
  localparam int STP_W      = $clog2(IDIV_STEPS);

  // scale constants
  localparam int FREQ_SCALE = 200;      // 2 * 100 for round half up
  localparam int INFO_SCALE = 4000;     // 2 * 1000 * 2
  localparam int INFO_BIAS  = 2001;
  localparam int SCALE_W    = 12;       // bits of INFO_SCALE

  localparam logic [INFO_W-1:0] INFO_ONE = INFO_W'(1000);
  localparam logic [FREQ_W-1:0] FREQ_MAX = FREQ_W'(100);

  // datapath operations
  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_NONE      = 3'd0;
  localparam logic [OP_W-1:0] OP_FDIV_LOAD = 3'd1;
  localparam logic [OP_W-1:0] OP_DIV_STEP  = 3'd2;
  localparam logic [OP_W-1:0] OP_FREQ_SET  = 3'd3;
  localparam logic [OP_W-1:0] OP_MUL_STEP  = 3'd4;
  localparam logic [OP_W-1:0] OP_MULQ_LOAD = 3'd5;
  localparam logic [OP_W-1:0] OP_IDIV_LOAD = 3'd6;
  localparam logic [OP_W-1:0] OP_INFO_SET  = 3'd7;

  typedef struct packed {
    logic [PROB_W-1:0] prob_het;
    logic [PROB_W-1:0] prob_hom_alt;
    logic              last_sample;
  } iis_in_word_t;

  typedef struct packed {
    logic [INFO_W-1:0] info_milli;
    logic [FREQ_W-1:0] freq_centi;
    logic [SEEN_W-1:0] samples_seen;
  } iis_out_word_t;

  typedef struct packed {
    logic            take;
    logic            clear;
    logic [OP_W-1:0] op;
  } iis_cmd_t;

  typedef struct packed {
    logic n_zero;
    logic freq_trivial;
    logic mplier_zero;
  } iis_sts_t;

endpackage

[sv/imputation_info_score.sv]
// ----------------------------------------------------------------------------
// imputation_info_score
// Per-site imputation info score and allele frequency from a stream of
// per-sample genotype probabilities.
// ----------------------------------------------------------------------------
// one word per sample while busy is low: a word is taken on any clock edge
// with start high and busy low, so a site streams in at one sample a cycle.
// the word flagged last_sample is itself a sample; after it busy rises and
// the site result is worked out, then shown for one cycle with out_strobe
// high. the receiver cannot stall, so it must take the word in that cycle.
// the per-site tail first drains the square stage; an empty site then goes
// straight to the result. otherwise the restoring divider runs 9 steps for
// the frequency, and a site whose rounded frequency is 0 or 100 or whose
// variance sum is not positive stops there; else two shift-add products
// follow, each stepping through the bits of its multiplier (n*4000 and
// 2N - dosage sum), then 12 divider steps for the score. samples beyond
// MAX_SAMPLES in one site are ignored but still counted out by the last
// flag
// ----------------------------------------------------------------------------
module imputation_info_score
  import iis_pkg::*;
#(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
)(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  iis_in_word_t  in_word,
  output logic          out_strobe,
  output iis_out_word_t out_word
);

  iis_cmd_t cmd;
  iis_sts_t sts;

  // sequencer
  iis_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .last       (in_word.last_sample),
    .sts        (sts),
    .cmd        (cmd),
    .busy       (busy),
    .out_strobe (out_strobe)
  );

  // accumulators and shared arithmetic
  iis_datapath #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_word  (in_word),
    .sts      (sts),
    .out_word (out_word)
  );

endmodule

[sv/iis_ctrl.sv]
// ----------------------------------------------------------------------------
// iis_ctrl
// Sequencer: takes sample words, then steps the datapath through the
// frequency divide, two shift-add products and the score divide.
// ----------------------------------------------------------------------------
module iis_ctrl
  import iis_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic     last,
  input  iis_sts_t sts,
  output iis_cmd_t cmd,
  output logic     busy,
  output logic     out_strobe
);

  localparam logic [3:0] ST_ACC   = 4'd0;
  localparam logic [3:0] ST_FLUSH = 4'd1;
  localparam logic [3:0] ST_FLOAD = 4'd2;
  localparam logic [3:0] ST_FDIV  = 4'd3;
  localparam logic [3:0] ST_FREQ  = 4'd4;
  localparam logic [3:0] ST_MULX  = 4'd5;
  localparam logic [3:0] ST_MULQ  = 4'd6;
  localparam logic [3:0] ST_IDIV  = 4'd7;
  localparam logic [3:0] ST_INFO  = 4'd8;
  localparam logic [3:0] ST_DONE  = 4'd9;

  logic [3:0]       state_r, state_nxt;
  logic [STP_W-1:0] stp_r, stp_nxt;

  always_comb begin
    state_nxt = state_r;
    stp_nxt   = stp_r;
    cmd.take  = 1'b0;
    cmd.clear = 1'b0;
    cmd.op    = OP_NONE;
    case (state_r)
      ST_ACC: begin
        if (start) begin
          cmd.take = 1'b1;
          if (last) begin
            state_nxt = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        state_nxt = ST_FLOAD;
      end
      ST_FLOAD: begin
        cmd.op    = OP_FDIV_LOAD;
        stp_nxt   = '0;
        state_nxt = sts.n_zero ? ST_DONE : ST_FDIV;
      end
      ST_FDIV: begin
        cmd.op = OP_DIV_STEP;
        if (stp_r == STP_W'(FQ_STEPS - 1)) begin
          stp_nxt   = '0;
          state_nxt = ST_FREQ;
        end else begin
          stp_nxt = stp_r + 1'b1;
        end
      end
      ST_FREQ: begin
        cmd.op    = OP_FREQ_SET;
        state_nxt = sts.freq_trivial ? ST_DONE : ST_MULX;
      end
      ST_MULX: begin
        if (sts.mplier_zero) begin
          cmd.op    = OP_MULQ_LOAD;
          state_nxt = ST_MULQ;
        end else begin
          cmd.op = OP_MUL_STEP;
        end
      end
      ST_MULQ: begin
        if (sts.mplier_zero) begin
          cmd.op    = OP_IDIV_LOAD;
          stp_nxt   = '0;
          state_nxt = ST_IDIV;
        end else begin
          cmd.op = OP_MUL_STEP;
        end
      end
      ST_IDIV: begin
        cmd.op = OP_DIV_STEP;
        if (stp_r == STP_W'(IDIV_STEPS - 1)) begin
          stp_nxt   = '0;
          state_nxt = ST_INFO;
        end else begin
          stp_nxt = stp_r + 1'b1;
        end
      end
      ST_INFO: begin
        cmd.op    = OP_INFO_SET;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        cmd.clear = 1'b1;
        state_nxt = ST_ACC;
      end
      default: begin
        state_nxt = ST_ACC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_ACC;
      stp_r   <= '0;
    end else begin
      state_r <= state_nxt;
      stp_r   <= stp_nxt;
    end
  end

  assign busy       = (state_r != ST_ACC);
  assign out_strobe = (state_r == ST_DONE);

endmodule

[sv/iis_datapath.sv]
// ----------------------------------------------------------------------------
// iis_datapath
// Sample accumulators with a registered square stage, plus one shared
// shift-add multiplier and restoring divider for the per-site result.
// ----------------------------------------------------------------------------
module iis_datapath
  import iis_pkg::*;
#(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
)(
  input  logic          clk,
  input  logic          rst_n,
  input  iis_cmd_t      cmd,
  input  iis_in_word_t  in_word,
  output iis_sts_t      sts,
  output iis_out_word_t out_word
);

  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int DOS_W  = A0_W + CNT_W;
  localparam int VAR_W  = TERM_W + CNT_W;
  localparam int MULA_W = CNT_W + SCALE_W;             // n * 4000
  localparam int DMS_W  = CNT_W + PROB_FRAC_BITS + 1;  // d - s
  localparam int FNUM_W = DOS_W + 9;                   // 200*s + d
  localparam int XW     = MULA_W + VAR_W - 1;
  localparam int QDW    = DOS_W + DMS_W + IDIV_STEPS;
  localparam int PW0    = (XW > QDW) ? XW : QDW;
  localparam int PW     = (PW0 > FNUM_W) ? PW0 : FNUM_W;
  localparam int MP_W   = (MULA_W > DMS_W) ? MULA_W : DMS_W;

  // square stage
  logic [A0_W-1:0] a0_c, a0_r, a0_nxt;
  logic [A1_W-1:0] a1_c, a1_r, a1_nxt;
  logic [SQ_W-1:0] sq_r, sq_nxt;
  logic            tv_r, tv_nxt;

  // site accumulators
  logic [DOS_W-1:0] dos_r, dos_nxt;
  logic [VAR_W-1:0] var_r, var_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // shared multiply / divide unit
  logic [PW-1:0]     rem_r, rem_nxt;
  logic [PW-1:0]     dvs_r, dvs_nxt;
  logic [PW-1:0]     acc_r, acc_nxt;
  logic [PW-1:0]     mcand_r, mcand_nxt;
  logic [MP_W-1:0]   mplier_r, mplier_nxt;
  logic [QUO_W-1:0]  quo_r, quo_nxt;
  logic [FREQ_W-1:0] freq_r, freq_nxt;
  logic [INFO_W-1:0] info_r, info_nxt;

  logic [QUO_W-1:0]  ceil_c;
  logic [INFO_W-1:0] info_c;
  logic [DMS_W-1:0]  dms_c;

  assign a0_c = A0_W'(in_word.prob_het) + A0_W'({in_word.prob_hom_alt, 1'b0});
  assign a1_c = A1_W'(in_word.prob_het) + A1_W'({in_word.prob_hom_alt, 2'b00});

  // sample path
  always_comb begin
    a0_nxt  = a0_r;
    a1_nxt  = a1_r;
    sq_nxt  = sq_r;
    tv_nxt  = 1'b0;
    cnt_nxt = cnt_r;
    dos_nxt = dos_r;
    var_nxt = var_r;
    if (cmd.take && (cnt_r < CNT_W'(MAX_SAMPLES))) begin
      a0_nxt  = a0_c;
      a1_nxt  = a1_c;
      sq_nxt  = SQ_W'(a0_c) * SQ_W'(a0_c);
      tv_nxt  = 1'b1;
      cnt_nxt = cnt_r + 1'b1;
    end
    if (tv_r) begin
      dos_nxt = dos_r + DOS_W'(a0_r);
      var_nxt = var_r + VAR_W'({a1_r, {PROB_FRAC_BITS{1'b0}}}) - VAR_W'(sq_r);
    end
    if (cmd.clear) begin
      cnt_nxt = '0;
      dos_nxt = '0;
      var_nxt = '0;
    end
  end

  // score from ceil(x / q): largest k with 2k <= 2001 - ceil(x/q)
  assign ceil_c = quo_r + QUO_W'(rem_r != '0);
  always_comb begin
    if (quo_r[QUO_W-1] || (ceil_c > QUO_W'(INFO_BIAS))) begin
      info_c = '0;
    end else begin
      info_c = INFO_W'((QUO_W'(INFO_BIAS) - ceil_c) >> 1);
    end
  end

  assign dms_c = (DMS_W'(cnt_r) << (PROB_FRAC_BITS + 1)) - DMS_W'(dos_r);

  // site result path
  always_comb begin
    rem_nxt    = rem_r;
    dvs_nxt    = dvs_r;
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    quo_nxt    = quo_r;
    freq_nxt   = freq_r;
    info_nxt   = info_r;
    case (cmd.op)
      OP_FDIV_LOAD: begin
        rem_nxt  = PW'(FNUM_W'(dos_r) * FNUM_W'(FREQ_SCALE))
                 + (PW'(cnt_r) << (PROB_FRAC_BITS + 1));
        dvs_nxt  = PW'(cnt_r) << (PROB_FRAC_BITS + 2 + FQ_STEPS - 1);
        quo_nxt  = '0;
        freq_nxt = '0;
        info_nxt = INFO_ONE;
      end
      OP_DIV_STEP: begin
        if (rem_r >= dvs_r) begin
          rem_nxt = rem_r - dvs_r;
          quo_nxt = {quo_r[QUO_W-2:0], 1'b1};
        end else begin
          quo_nxt = {quo_r[QUO_W-2:0], 1'b0};
        end
        dvs_nxt = dvs_r >> 1;
      end
      OP_FREQ_SET: begin
        freq_nxt   = (quo_r >= QUO_W'(FREQ_MAX)) ? FREQ_MAX : quo_r[FREQ_W-1:0];
        acc_nxt    = '0;
        mcand_nxt  = PW'(var_r[VAR_W-2:0]);
        mplier_nxt = MP_W'(MULA_W'(cnt_r) * MULA_W'(INFO_SCALE));
      end
      OP_MUL_STEP: begin
        if (mplier_r[0]) begin
          acc_nxt = acc_r + mcand_r;
        end
        mcand_nxt  = mcand_r << 1;
        mplier_nxt = mplier_r >> 1;
      end
      OP_MULQ_LOAD: begin
        rem_nxt    = acc_r;
        acc_nxt    = '0;
        mcand_nxt  = PW'(dos_r);
        mplier_nxt = MP_W'(dms_c);
      end
      OP_IDIV_LOAD: begin
        dvs_nxt = acc_r << (IDIV_STEPS - 1);
        quo_nxt = '0;
      end
      OP_INFO_SET: begin
        info_nxt = info_c;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tv_r  <= 1'b0;
      cnt_r <= '0;
      dos_r <= '0;
      var_r <= '0;
    end else begin
      tv_r  <= tv_nxt;
      cnt_r <= cnt_nxt;
      dos_r <= dos_nxt;
      var_r <= var_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a0_r     <= a0_nxt;
    a1_r     <= a1_nxt;
    sq_r     <= sq_nxt;
    rem_r    <= rem_nxt;
    dvs_r    <= dvs_nxt;
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    quo_r    <= quo_nxt;
    freq_r   <= freq_nxt;
    info_r   <= info_nxt;
  end

  assign sts.n_zero       = (cnt_r == '0);
  assign sts.freq_trivial = (quo_r == '0) || (quo_r >= QUO_W'(FREQ_MAX))
                          || var_r[VAR_W-1] || (var_r == '0);
  assign sts.mplier_zero  = (mplier_r == '0);

  assign out_word.info_milli   = info_r;
  assign out_word.freq_centi   = freq_r;
  assign out_word.samples_seen = SEEN_W'(cnt_r);

endmodule

[sv/iis_checker.sv]
// ----------------------------------------------------------------------------
// iis_checker
// Port-level checks on the result timing and result ranges.
// ----------------------------------------------------------------------------
module iis_checker
  import iis_pkg::*;
(
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input iis_in_word_t  in_word,
  input logic          out_strobe,
  input iis_out_word_t out_word
);

  // a flagged last word hands control to the result sequence
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_word.last_sample |=> busy)
    else $error("busy not raised after last sample");

  // the result word ends the sequence and is shown once
  a_strobe_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy ##1 (!busy && !out_strobe))
    else $error("result strobe timing wrong");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_word.info_milli <= INFO_ONE) && (out_word.freq_centi <= FREQ_MAX))
    else $error("result out of range");

  // rounded frequency of zero or one gives a full score
  a_trivial: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && ((out_word.freq_centi == '0) || (out_word.freq_centi == FREQ_MAX))
      |-> (out_word.info_milli == INFO_ONE))
    else $error("full score expected");

endmodule

bind imputation_info_score iis_checker u_iis_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_word    (in_word),
  .out_strobe (out_strobe),
  .out_word   (out_word)
);

[bench/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for imputation_info_score. Sites of per-sample genotype
// probabilities are streamed in with random gaps, and each site result is
// checked field by field against a bit-exact integer predictor of the score.
// ----------------------------------------------------------------------------
module tb;
  import iis_pkg::*;

  // site size limit of the instance, kept at its default
  localparam int unsigned SITE_CAP      = MAX_SAMPLES_DEF;
  localparam int unsigned ITEM_TARGET   = 1900;
  localparam int unsigned CALM_TAIL     = 300;        // final words with no gaps
  localparam int unsigned SETTLE_CYCLES = 150;        // beyond the longest site tail
  localparam longint unsigned CYCLE_LIMIT = 2_000_000;

  typedef enum int {
    MODE_CONFIDENT,
    MODE_SPREAD,
    MODE_RARE,
    MODE_CORNER,
    MODE_NOISE
  } sample_mode_e;

  // --------------------------------------------------------------------------
  // site score tracker: keeps its own copy of the site sums and a queue of
  // the site results still owed by the block
  // --------------------------------------------------------------------------
  class site_score_tracker;
    longint unsigned dose_acc;
    longint          var_acc;
    int unsigned     n_acc;
    iis_out_word_t   owed_sites[$];
    int unsigned     faults;

    function new();
      dose_acc = 0;
      var_acc  = 0;
      n_acc    = 0;
      faults   = 0;
    endfunction

    function int unsigned owed();
      return owed_sites.size();
    endfunction

    // exact score of the site held in the sums
    function iis_out_word_t site_score();
      iis_out_word_t   res;
      longint unsigned two_n_q, freq;
      bit [127:0]      lhs, span, ratio;
      res.info_milli   = INFO_ONE;
      res.freq_centi   = '0;
      res.samples_seen = SEEN_W'(n_acc);
      if (n_acc != 0) begin
        two_n_q = longint'(2 * n_acc) << PROB_FRAC_BITS;
        // round half up to hundredths
        freq = (FREQ_SCALE * dose_acc + two_n_q) / (2 * two_n_q);
        if (freq > FREQ_MAX) freq = FREQ_MAX;
        res.freq_centi = FREQ_W'(freq);
        if (freq > 0 && freq < FREQ_MAX && var_acc > 0) begin
          // largest k with 2000*2N*V <= (2001 - 2k) * S * (D - S)
          lhs   = 128'(n_acc) * 128'(INFO_SCALE) * 128'(var_acc);
          span  = 128'(dose_acc) * 128'(two_n_q - dose_acc);
          ratio = (lhs + span - 1) / span;
          if (ratio > INFO_BIAS) res.info_milli = '0;
          else res.info_milli = INFO_W'((INFO_BIAS - ratio) / 2);
        end
      end
      return res;
    endfunction

    // an accepted word: accumulate unless the site is full, close on last
    function void take_sample(iis_in_word_t w);
      longint unsigned a0, a1;
      if (n_acc < SITE_CAP) begin
        a0 = longint'(w.prob_het) + 2 * longint'(w.prob_hom_alt);
        a1 = longint'(w.prob_het) + 4 * longint'(w.prob_hom_alt);
        dose_acc += a0;
        var_acc  += longint'(a1 << PROB_FRAC_BITS) - longint'(a0 * a0);
        n_acc++;
      end
      if (w.last_sample) begin
        owed_sites.push_back(site_score());
        dose_acc = 0;
        var_acc  = 0;
        n_acc    = 0;
      end
    endfunction

    function void check_result(iis_out_word_t got);
      iis_out_word_t want;
      if (owed_sites.size() == 0) begin
        $error("result word with no site pending: %p", got);
        faults++;
        return;
      end
      want = owed_sites.pop_front();
      if (got.info_milli !== want.info_milli) begin
        $error("info_milli: expected %0d, got %0d", want.info_milli, got.info_milli);
        faults++;
      end
      if (got.freq_centi !== want.freq_centi) begin
        $error("freq_centi: expected %0d, got %0d", want.freq_centi, got.freq_centi);
        faults++;
      end
      if (got.samples_seen !== want.samples_seen) begin
        $error("samples_seen: expected %0d, got %0d",
               want.samples_seen, got.samples_seen);
        faults++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and the block
  // --------------------------------------------------------------------------
  logic          clk = 1'b0;
  logic          rst_n;
  logic          start;
  logic          busy;
  iis_in_word_t  in_word;
  logic          out_strobe;
  iis_out_word_t out_word;

  site_score_tracker tracker = new();

  bit              idle_on;
  int unsigned     words_sent;
  longint unsigned cycles;

  int unsigned corner_vals[7] = '{0, 1, 16384, 32767, 32768, 32769, 65535};

  always #5 clk = ~clk;

  imputation_info_score #(
    .MAX_SAMPLES (SITE_CAP)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_word    (in_word),
    .out_strobe (out_strobe),
    .out_word   (out_word)
  );

  // --------------------------------------------------------------------------
  // monitor: values read here are those before the edge, so a word is taken
  // exactly when the block takes it; a result word is only ever shown for one
  // cycle and must be picked up on that edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) tracker.take_sample(in_word);
      if (out_strobe) tracker.check_result(out_word);
    end
  end

  // watchdog against a hung block or a lost result
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // driving
  // --------------------------------------------------------------------------

  // offer one word and hold it until taken; entered and left on a rising edge
  task automatic send_probs(input int unsigned het, input int unsigned hom,
                            input bit last);
    iis_in_word_t w;
    w.prob_het     = PROB_W'(het);
    w.prob_hom_alt = PROB_W'(hom);
    w.last_sample  = last;
    start   <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    words_sent++;
    // a burst of idling now and then, which also lands on the site tail
    if (idle_on && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  // stop offering words until every owed site result has come back
  task automatic settle();
    start <= 1'b0;
    while (tracker.owed() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one sample of a given flavour, as a het / hom-alt pair
  task automatic draw_sample(input sample_mode_e mode, output int unsigned het,
                             output int unsigned hom);
    int unsigned err, part;
    err  = $urandom_range(0, 3000);
    part = $urandom_range(0, err);
    case (mode)
      MODE_CONFIDENT: begin
        // near-certain genotype, as a good imputation gives
        case ($urandom_range(0, 2))
          0: begin het = part;         hom = err - part;   end
          1: begin het = 32768 - err;  hom = part;         end
          default: begin het = part;   hom = 32768 - err;  end
        endcase
      end
      MODE_SPREAD: begin
        het = $urandom_range(0, 32768);
        hom = $urandom_range(0, 32768 - het);
      end
      MODE_RARE: begin
        // mostly homozygous reference, so the frequency sits near zero
        het = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 32768) : 0;
        hom = ($urandom_range(0, 30) == 0) ? $urandom_range(0, 32768 - het) : 0;
      end
      MODE_CORNER: begin
        het = corner_vals[$urandom_range(0, 6)];
        hom = corner_vals[$urandom_range(0, 6)];
      end
      default: begin
        // out-of-range probabilities, every bit free
        het = $urandom_range(0, 65535);
        hom = $urandom_range(0, 65535);
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    int unsigned  site_len, het, hom;
    int unsigned  pick;
    sample_mode_e mode;
    bit           paused;

    rst_n      = 1'b0;
    start      = 1'b0;
    in_word    = '0;
    idle_on    = 1'b0;
    words_sent = 0;
    cycles     = 0;
    paused     = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed sites, mostly single-sample
    send_probs(0, 0, 1);              // frequency rounds to zero
    send_probs(0, 32768, 1);          // frequency exactly one
    send_probs(65535, 65535, 1);      // frequency above one, saturates
    send_probs(32768, 0, 1);          // zero variance, score one
    send_probs(0, 16384, 1);          // score below zero, clamped
    send_probs(65535, 0, 1);          // negative variance sum
    send_probs(1, 0, 1);              // smallest nonzero dosage
    send_probs(16384, 8192, 0);       // a mid-range site
    send_probs(8192, 0, 0);
    send_probs(0, 32768, 1);
    send_probs(32767, 32767, 0);      // extremes inside one site
    send_probs(0, 1, 0);
    send_probs(65535, 0, 0);
    send_probs(0, 65535, 1);
    idle_on = 1'b1;
    send_probs(20000, 6000, 0);       // same again with gaps allowed
    send_probs(3000, 1000, 0);
    send_probs(12000, 2000, 1);
    settle();

    // random sites of random flavour
    while (words_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) mode = MODE_CONFIDENT;
      else if (pick < 7) mode = MODE_SPREAD;
      else if (pick == 7) mode = MODE_RARE;
      else if (pick == 8) mode = MODE_CORNER;
      else mode = MODE_NOISE;
      // short sites mostly, a long one now and then
      site_len = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 400)
                                             : $urandom_range(1, 24);
      // stretches with no gaps, and none at all near the end
      idle_on = ($urandom_range(0, 3) != 0) &&
                (words_sent + CALM_TAIL < ITEM_TARGET);
      for (int unsigned i = 0; i < site_len; i++) begin
        draw_sample(mode, het, hom);
        send_probs(het, hom, i == site_len - 1);
      end
      // hold off once mid-run until the block has fully drained
      if (!paused && words_sent > ITEM_TARGET / 2) begin
        paused = 1'b1;
        settle();
      end
    end

    settle();
    if (tracker.faults == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
